// ===== rtl/core/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
package spq_pkg;

	localparam int CAPACITY  = 16;
	localparam int RANK_BITS = 8;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// input selector codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_DELETE = 2'd1;
	localparam logic [1:0] MODE_LIST   = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_LIST
	} state_t;

	typedef struct packed {
		logic [31:0]          value;
		logic [RANK_BITS-1:0] rank;
	} entry_t;

	typedef struct packed {
		cell_op_t             op;
		logic [31:0]          new_value;
		logic [RANK_BITS-1:0] new_rank;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic               occ_self,
	input  logic               occ_prev,
	input  logic               occ_next,
	input  spq_pkg::entry_t    prev,
	input  spq_pkg::entry_t    next,
	input  spq_pkg::entry_t    head,
	output spq_pkg::entry_t    slot
);
	import spq_pkg::*;

	entry_t slot_q;
	entry_t slot_d;

	always_comb begin
		slot_d = slot_q;
		case (ctrl.op)
			OP_INSERT: begin
				// stay if ours ranks at or before the new one; else new item or shift back
				if (occ_self && (slot_q.rank <= ctrl.new_rank)) begin
					slot_d = slot_q;
				end else if (occ_prev && (prev.rank <= ctrl.new_rank)) begin
					slot_d.value = ctrl.new_value;
					slot_d.rank  = ctrl.new_rank;
				end else begin
					slot_d = prev;
				end
			end
			OP_DELETE: begin
				slot_d = next;
			end
			OP_ROTATE: begin
				// tail of the occupied run wraps the front entry around
				if (occ_next) begin
					slot_d = next;
				end else if (occ_self) begin
					slot_d = head;
				end
			end
			default: begin
				slot_d = slot_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_d;
	end

	assign slot = slot_q;

endmodule

// ===== rtl/core/sorted_priority_queue_unit.sv =====
// Top level of the sorted priority queue: cell chain, fill count, listing control, result register.
//
//  channel   dir  tdata (low bit up)              tuser            tlast
//  s_axis    in   item_value[31:0] item_rank[39:32] mode[1:0]      -
//  m_axis    out  out_value[31:0]  out_rank[39:32]  status[1:0]    last
//
// Insert and delete update every cell in parallel from its neighbors and the
// broadcast item, so one transaction is taken per cycle while idle and the output is free.
// A listing first loads the counter from the fill count, then gives one result
// per cycle while the chain rotates by one slot, ending in original order.
// Reset clears the fill count, the listing counter and state and the output valid
// flag; slot contents and result data are not reset. An output stall holds the
// result register and freezes the rotation; a new input transaction is taken only outside a listing.
module sorted_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // item_value[31:0], item_rank[39:32]
	input  logic [1:0]  s_axis_tuser,  // mode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // out_value[31:0], out_rank[39:32]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	output logic        m_axis_tlast
);
	import spq_pkg::*;

	state_t          state_q, state_d;
	logic [CNT_W-1:0] fill_q, fill_d;
	logic [CNT_W-1:0] left_q, left_d;

	logic            out_valid_q;
	logic [1:0]      out_status_q, out_status_d;
	logic [31:0]     out_value_q, out_value_d;
	logic [7:0]      out_rank_q, out_rank_d;
	logic            out_last_q, out_last_d;
	logic            load_out;

	cell_ctrl_t      ctrl;
	entry_t          slots [CAPACITY];
	logic [CAPACITY-1:0] occ;

	logic            out_free;
	logic            in_acc;
	logic [1:0]      in_mode;
	logic [31:0]     in_value;
	logic [7:0]      in_rank;
	logic            full;
	logic            empty;

	assign in_mode  = s_axis_tuser;
	assign in_value = s_axis_tdata[31:0];
	assign in_rank  = s_axis_tdata[39:32];

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign full  = occ[CAPACITY-1];
	assign empty = !occ[0];

	// ---------------- cell chain ----------------
	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   occ_p;
			logic   occ_n;

			// thermometer occupancy from the fill count
			assign occ[gi] = (CNT_W'(gi) < fill_q);

			if (gi == 0) begin : g_first
				// virtual front neighbor: always occupied, lowest rank
				assign prev_e = '0;
				assign occ_p  = 1'b1;
			end else begin : g_mid_p
				assign prev_e = slots[gi-1];
				assign occ_p  = occ[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign next_e = slots[gi];
				assign occ_n  = 1'b0;
			end else begin : g_mid_n
				assign next_e = slots[gi+1];
				assign occ_n  = occ[gi+1];
			end

			spq_cell u_cell (
				.clk      (clk),
				.ctrl     (ctrl),
				.occ_self (occ[gi]),
				.occ_prev (occ_p),
				.occ_next (occ_n),
				.prev     (prev_e),
				.next     (next_e),
				.head     (slots[0]),
				.slot     (slots[gi])
			);
		end
	endgenerate

	// ---------------- next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && (in_mode == MODE_LIST) && !empty) begin
					state_d = ST_LIST;
				end
			end
			ST_LIST: begin
				if (out_free && (left_q == CNT_W'(1))) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- outputs / datapath control ----------------
	always_comb begin
		ctrl.op        = OP_HOLD;
		ctrl.new_value = in_value;
		ctrl.new_rank  = in_rank[RANK_BITS-1:0];
		fill_d         = fill_q;
		left_d         = left_q;
		load_out       = 1'b0;
		out_status_d   = STAT_OK;
		out_value_d    = '0;
		out_rank_d     = '0;
		out_last_d     = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_mode)
						MODE_INSERT: begin
							load_out = 1'b1;
							if (full) begin
								out_status_d = STAT_FULL;
							end else begin
								ctrl.op = OP_INSERT;
								fill_d  = fill_q + CNT_W'(1);
							end
						end
						MODE_DELETE: begin
							load_out = 1'b1;
							if (empty) begin
								out_status_d = STAT_EMPTY;
							end else begin
								ctrl.op     = OP_DELETE;
								fill_d      = fill_q - CNT_W'(1);
								out_value_d = slots[0].value;
								out_rank_d  = 8'(slots[0].rank);
							end
						end
						MODE_LIST: begin
							if (empty) begin
								load_out     = 1'b1;
								out_status_d = STAT_EMPTY;
							end else begin
								left_d = fill_q;
							end
						end
						default: begin
							// unused selector: dropped silently
							load_out = 1'b0;
						end
					endcase
				end
			end
			ST_LIST: begin
				if (out_free) begin
					ctrl.op     = OP_ROTATE;
					load_out    = 1'b1;
					out_value_d = slots[0].value;
					out_rank_d  = 8'(slots[0].rank);
					out_last_d  = (left_q == CNT_W'(1));
					left_d      = left_q - CNT_W'(1);
				end
			end
			default: begin
				ctrl.op = OP_HOLD;
			end
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			left_q  <= left_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= out_status_d;
			out_value_q  <= out_value_d;
			out_rank_q   <= out_rank_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_rank_q, out_value_q};
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// fill count never runs past the chain length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count exceeds capacity");

	// a dropped insert leaves the queue untouched
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (in_mode == MODE_INSERT) && full) |=> $stable(fill_q))
		else $error("insert to full queue changed fill count");

	// final listing step presents a result marked last
	a_list_last: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LIST) && out_free && (left_q == CNT_W'(1)))
		|=> (m_axis_tvalid && m_axis_tlast && (state_q == ST_IDLE)))
		else $error("listing did not end with last");

	// no new input transaction while a listing is in progress
	a_list_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LIST) |-> !in_acc)
		else $error("input taken during listing");
`endif

endmodule
